FILE: hdl/nwc_pkg.sv
// Shared types and constants for the northwest corner transport block.
// Used by nwc_controller, nwc_datapath and northwest_corner_transport_top.
package nwc_pkg;

    localparam int CFG_W     = 6;   // width of the size registers
    localparam int CFG_IDX_W = 1;   // width of the register index
    localparam int IDX_W     = 5;   // width of the item index fields
    localparam int VAL_W     = 32;  // width of loaded values and cost words
    localparam int WGT_W     = 32;  // width of the weight result field
    localparam int SUM_W     = 64;  // width of the cost accumulator

    // Item operation codes
    typedef enum logic [1:0] {
        OP_LOAD_SUPPLY = 2'd0,
        OP_LOAD_DEMAND = 2'd1,
        OP_LOAD_COST   = 2'd2,
        OP_RUN         = 2'd3
    } op_t;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SOURCES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SINKS   = 1'b1;

    // Controller states, one-hot
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_LOAD   = 8'b0000_0010,
        ST_TAKE   = 8'b0000_0100,
        ST_MUL_LO = 8'b0000_1000,
        ST_MUL_HI = 8'b0001_0000,
        ST_MERGE  = 8'b0010_0000,
        ST_ACCUM  = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic wr_supply;
        logic wr_demand;
        logic wr_cost;
        logic init;
        logic take;
        logic mul_lo;
        logic mul_hi;
        logic merge;
        logic accum;
        logic finish;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic at_end;   // source or sink index ran past its configured size
        logic alloc;    // current supply and demand are both nonzero
    } stat_t;

endpackage

FILE: hdl/nwc_controller.sv
// Sequencer for the northwest corner transport block.
// Depends on nwc_pkg for state, command and status types.
module nwc_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     op,
    output logic           busy,
    output nwc_pkg::cmd_t  cmd,
    input  nwc_pkg::stat_t stat
);
    import nwc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_LOAD_SUPPLY: cmd.wr_supply = 1'b1;
                        OP_LOAD_DEMAND: cmd.wr_demand = 1'b1;
                        OP_LOAD_COST:   cmd.wr_cost   = 1'b1;
                        OP_RUN:
                        begin
                            cmd.init   = 1'b1;
                            state_next = ST_LOAD;
                        end
                        default: cmd = '0;
                    endcase
                end
            end
            ST_LOAD:
            begin
                state_next = ST_TAKE;
            end
            ST_TAKE:
            begin
                cmd.take = 1'b1;
                priority if (stat.at_end)
                    state_next = ST_FINISH;
                else if (stat.alloc)
                    state_next = ST_MUL_LO;
                else
                    state_next = ST_LOAD;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = ST_TAKE;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: hdl/nwc_datapath.sv
// Datapath of the northwest corner transport block: stores, walk indices,
// shared multiplier, saturating accumulator and result registers.
// Depends on nwc_pkg; driven by nwc_controller commands.
module nwc_datapath #(
    parameter int MAX_SOURCES = 32,
    parameter int MAX_SINKS   = 32,
    parameter int MASS_WIDTH  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nwc_pkg::cmd_t                  cmd,
    output nwc_pkg::stat_t                 stat,
    input  logic [nwc_pkg::IDX_W-1:0]      row_index,
    input  logic [nwc_pkg::IDX_W-1:0]      col_index,
    input  logic [nwc_pkg::VAL_W-1:0]      value,
    input  logic                           cfg_write,
    input  logic [nwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nwc_pkg::CFG_W-1:0]      cfg_data,
    output logic                           result_valid,
    output logic [nwc_pkg::IDX_W-1:0]      src_index,
    output logic [nwc_pkg::IDX_W-1:0]      dst_index,
    output logic [nwc_pkg::WGT_W-1:0]      weight,
    output logic [nwc_pkg::SUM_W-1:0]      total_cost,
    output logic                           empty_flag,
    output logic                           last
);
    import nwc_pkg::*;

    localparam int SAW = $clog2(MAX_SOURCES);
    localparam int KAW = $clog2(MAX_SINKS);
    localparam int SIW = $clog2(MAX_SOURCES + 1);
    localparam int KIW = $clog2(MAX_SINKS + 1);
    localparam int CAW = $clog2(MAX_SOURCES * MAX_SINKS);

    // Stores
    logic [MASS_WIDTH-1:0] supply_mem [MAX_SOURCES];
    logic [MASS_WIDTH-1:0] demand_mem [MAX_SINKS];
    logic [VAL_W-1:0]      cost_mem   [MAX_SOURCES * MAX_SINKS];

    logic [MASS_WIDTH-1:0] s_rd_reg;
    logic [MASS_WIDTH-1:0] d_rd_reg;
    logic [VAL_W-1:0]      c_rd_reg;

    // Configuration
    logic [CFG_W-1:0] cfg_src_reg, cfg_src_next;
    logic [CFG_W-1:0] cfg_snk_reg, cfg_snk_next;
    logic [SIW-1:0]   ns_reg, ns_next, ns_clamp;
    logic [KIW-1:0]   nk_reg, nk_next, nk_clamp;

    // Walk state
    logic [SIW-1:0]        i_reg, i_next;
    logic [KIW-1:0]        j_reg, j_next;
    logic                  load_s_reg, load_s_next;
    logic                  load_d_reg, load_d_next;
    logic [MASS_WIDTH-1:0] s_cur_reg, s_cur_next;
    logic [MASS_WIDTH-1:0] d_cur_reg, d_cur_next;
    logic [MASS_WIDTH-1:0] s_val, d_val, w_take;
    logic                  adv_i, adv_j, at_end, alloc;

    // Pending allocation, held until it is known whether it is the last
    logic                  pend_valid_reg, pend_valid_next;
    logic [SIW-1:0]        pend_i_reg, pend_i_next;
    logic [KIW-1:0]        pend_j_reg, pend_j_next;
    logic [MASS_WIDTH-1:0] pend_w_reg, pend_w_next;

    // Cost arithmetic
    logic [MASS_WIDTH-1:0] w_reg, w_next;
    logic [VAL_W-1:0]      cost_reg, cost_next;
    logic [SUM_W-1:0]      w_pad;
    logic [31:0]           mul_a;
    logic [SUM_W-1:0]      mul_p;
    logic [SUM_W-1:0]      prod_lo_reg, prod_lo_next;
    logic [SUM_W-1:0]      prod_hi_reg, prod_hi_next;
    logic [SUM_W-1:0]      prod_reg, prod_next;
    logic [SUM_W-1:0]      acc_reg, acc_next;
    logic [SUM_W:0]        merge_sum, acc_sum;

    // Results
    logic                  valid_reg, valid_next;
    logic [IDX_W-1:0]      src_reg, src_next;
    logic [IDX_W-1:0]      dst_reg, dst_next;
    logic [WGT_W-1:0]      wgt_reg, wgt_next;
    logic [SUM_W-1:0]      tot_reg, tot_next;
    logic                  empty_reg, empty_next;
    logic                  last_reg, last_next;

    logic                  row_ok, col_ok;
    logic [CAW-1:0]        cost_waddr, cost_raddr;

    assign row_ok     = (int'(row_index) < MAX_SOURCES);
    assign col_ok     = (int'(col_index) < MAX_SINKS);
    assign cost_waddr = CAW'(int'(row_index[SAW-1:0]) * MAX_SINKS + int'(col_index[KAW-1:0]));
    assign cost_raddr = CAW'(int'(i_reg[SAW-1:0]) * MAX_SINKS + int'(j_reg[KAW-1:0]));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_supply && row_ok)
            supply_mem[row_index[SAW-1:0]] <= MASS_WIDTH'(value);
        s_rd_reg <= supply_mem[i_reg[SAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_demand && col_ok)
            demand_mem[col_index[KAW-1:0]] <= MASS_WIDTH'(value);
        d_rd_reg <= demand_mem[j_reg[KAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_cost && row_ok && col_ok)
            cost_mem[cost_waddr] <= value;
        c_rd_reg <= cost_mem[cost_raddr];
    end

    // Size clamp: zero acts as one, above the maximum acts as the maximum
    always_comb
    begin
        priority if (cfg_src_reg == '0)
            ns_clamp = SIW'(1);
        else if (cfg_src_reg > CFG_W'(MAX_SOURCES))
            ns_clamp = SIW'(MAX_SOURCES);
        else
            ns_clamp = SIW'(cfg_src_reg);
        priority if (cfg_snk_reg == '0)
            nk_clamp = KIW'(1);
        else if (cfg_snk_reg > CFG_W'(MAX_SINKS))
            nk_clamp = KIW'(MAX_SINKS);
        else
            nk_clamp = KIW'(cfg_snk_reg);
    end

    assign s_val  = load_s_reg ? s_rd_reg : s_cur_reg;
    assign d_val  = load_d_reg ? d_rd_reg : d_cur_reg;
    assign adv_i  = (s_val <= d_val);
    assign adv_j  = (d_val <= s_val);
    assign w_take = adv_i ? s_val : d_val;
    assign at_end = (i_reg >= ns_reg) || (j_reg >= nk_reg);
    assign alloc  = (s_val != '0) && (d_val != '0);

    assign stat.at_end = at_end;
    assign stat.alloc  = alloc;

    // One 32x32 multiplier, shared by the low and high halves of the weight
    assign w_pad     = SUM_W'(w_reg);
    assign mul_a     = cmd.mul_hi ? w_pad[63:32] : w_pad[31:0];
    assign mul_p     = SUM_W'(mul_a) * SUM_W'(cost_reg);
    assign merge_sum = {1'b0, prod_lo_reg} + {1'b0, prod_hi_reg[31:0], 32'd0};
    assign acc_sum   = {1'b0, acc_reg} + {1'b0, prod_reg};

    always_comb
    begin
        cfg_src_next    = cfg_src_reg;
        cfg_snk_next    = cfg_snk_reg;
        ns_next         = ns_reg;
        nk_next         = nk_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        load_s_next     = load_s_reg;
        load_d_next     = load_d_reg;
        s_cur_next      = s_cur_reg;
        d_cur_next      = d_cur_reg;
        pend_valid_next = pend_valid_reg;
        pend_i_next     = pend_i_reg;
        pend_j_next     = pend_j_reg;
        pend_w_next     = pend_w_reg;
        w_next          = w_reg;
        cost_next       = cost_reg;
        prod_lo_next    = prod_lo_reg;
        prod_hi_next    = prod_hi_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        valid_next      = 1'b0;
        src_next        = src_reg;
        dst_next        = dst_reg;
        wgt_next        = wgt_reg;
        tot_next        = tot_reg;
        empty_next      = empty_reg;
        last_next       = last_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_NUM_SOURCES: cfg_src_next = cfg_data;
                REG_NUM_SINKS:   cfg_snk_next = cfg_data;
                default:         cfg_src_next = cfg_src_reg;
            endcase
        end

        if (cmd.init)
        begin
            ns_next         = ns_clamp;
            nk_next         = nk_clamp;
            i_next          = '0;
            j_next          = '0;
            load_s_next     = 1'b1;
            load_d_next     = 1'b1;
            pend_valid_next = 1'b0;
            acc_next        = '0;
        end

        if (cmd.take && !at_end)
        begin
            if (!alloc)
            begin
                // Skip zero entries; reload whichever side advances
                s_cur_next  = s_val;
                d_cur_next  = d_val;
                load_s_next = (s_val == '0);
                load_d_next = (d_val == '0);
                if (s_val == '0)
                    i_next = i_reg + SIW'(1);
                if (d_val == '0)
                    j_next = j_reg + KIW'(1);
            end
            else
            begin
                // Release the previous allocation, hold this one back
                if (pend_valid_reg)
                begin
                    valid_next = 1'b1;
                    src_next   = IDX_W'(pend_i_reg);
                    dst_next   = IDX_W'(pend_j_reg);
                    wgt_next   = WGT_W'(pend_w_reg);
                    tot_next   = '0;
                    empty_next = 1'b0;
                    last_next  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_i_next     = i_reg;
                pend_j_next     = j_reg;
                pend_w_next     = w_take;
                w_next          = w_take;
                cost_next       = c_rd_reg;
                s_cur_next      = s_val - w_take;
                d_cur_next      = d_val - w_take;
                load_s_next     = adv_i;
                load_d_next     = adv_j;
                if (adv_i)
                    i_next = i_reg + SIW'(1);
                if (adv_j)
                    j_next = j_reg + KIW'(1);
            end
        end

        if (cmd.mul_lo)
            prod_lo_next = mul_p;
        if (cmd.mul_hi)
            prod_hi_next = mul_p;
        if (cmd.merge)
        begin
            if ((prod_hi_reg[63:32] != '0) || merge_sum[SUM_W])
                prod_next = '1;
            else
                prod_next = merge_sum[SUM_W-1:0];
        end
        if (cmd.accum)
        begin
            if (acc_sum[SUM_W])
                acc_next = '1;
            else
                acc_next = acc_sum[SUM_W-1:0];
        end

        if (cmd.finish)
        begin
            valid_next = 1'b1;
            last_next  = 1'b1;
            if (pend_valid_reg)
            begin
                src_next   = IDX_W'(pend_i_reg);
                dst_next   = IDX_W'(pend_j_reg);
                wgt_next   = WGT_W'(pend_w_reg);
                tot_next   = acc_reg;
                empty_next = 1'b0;
            end
            else
            begin
                src_next   = '0;
                dst_next   = '0;
                wgt_next   = '0;
                tot_next   = '0;
                empty_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_src_reg    <= CFG_W'(MAX_SOURCES);
            cfg_snk_reg    <= CFG_W'(MAX_SINKS);
            ns_reg         <= SIW'(MAX_SOURCES);
            nk_reg         <= KIW'(MAX_SINKS);
            i_reg          <= '0;
            j_reg          <= '0;
            load_s_reg     <= 1'b0;
            load_d_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            acc_reg        <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            cfg_src_reg    <= cfg_src_next;
            cfg_snk_reg    <= cfg_snk_next;
            ns_reg         <= ns_next;
            nk_reg         <= nk_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            load_s_reg     <= load_s_next;
            load_d_reg     <= load_d_next;
            pend_valid_reg <= pend_valid_next;
            acc_reg        <= acc_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_cur_reg   <= s_cur_next;
        d_cur_reg   <= d_cur_next;
        pend_i_reg  <= pend_i_next;
        pend_j_reg  <= pend_j_next;
        pend_w_reg  <= pend_w_next;
        w_reg       <= w_next;
        cost_reg    <= cost_next;
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        prod_reg    <= prod_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        wgt_reg     <= wgt_next;
        tot_reg     <= tot_next;
        empty_reg   <= empty_next;
        last_reg    <= last_next;
    end

    assign result_valid = valid_reg;
    assign src_index    = src_reg;
    assign dst_index    = dst_reg;
    assign weight       = wgt_reg;
    assign total_cost   = tot_reg;
    assign empty_flag   = empty_reg;
    assign last         = last_reg;

endmodule

FILE: hdl/northwest_corner_transport_top.sv
// Top level of the northwest corner transport block.
// Depends on nwc_pkg, nwc_controller and nwc_datapath.
//
// Command channel: an item transfers at a rising edge where start is high and
// busy is low. op selects load supply (row_index), load demand (col_index),
// load cost word (row_index, col_index) or run. Loads leave busy low and
// give no result.
// A run walks the supply and demand stores in order, fetching each entry as
// the walk reaches it. After the accepting edge it fetches the first entries,
// then steps past zero entries or makes an allocation (weight times cost in
// two halves through one 32x32 multiplier, a saturating merge, a saturating
// accumulate), and at the end of the walk it closes the run. busy
// drops in the cycle that presents the final result.
// Results: result_valid strobes for one cycle per transfer with src_index,
// dst_index and weight; each allocation appears once the next is found. The
// final transfer has last set and carries total_cost; a run that moves
// nothing gives one transfer with empty_flag and last set. The receiver
// cannot stall, so results are never held.
// Configuration: cfg_write with cfg_index and cfg_data, taken at once; write
// only while busy is low. Reset sets both sizes to their maximum; the stores
// are not cleared and must be loaded before a run reads them.
module northwest_corner_transport_top #(
    parameter int MAX_SOURCES = 32,
    parameter int MAX_SINKS   = 32,
    parameter int MASS_WIDTH  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     op,
    input  logic [nwc_pkg::IDX_W-1:0]      row_index,
    input  logic [nwc_pkg::IDX_W-1:0]      col_index,
    input  logic [nwc_pkg::VAL_W-1:0]      value,
    input  logic                           cfg_write,
    input  logic [nwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nwc_pkg::CFG_W-1:0]      cfg_data,
    output logic                           result_valid,
    output logic [nwc_pkg::IDX_W-1:0]      src_index,
    output logic [nwc_pkg::IDX_W-1:0]      dst_index,
    output logic [nwc_pkg::WGT_W-1:0]      weight,
    output logic [nwc_pkg::SUM_W-1:0]      total_cost,
    output logic                           empty_flag,
    output logic                           last
);
    import nwc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequence loads and the walk
    nwc_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Hold stores, walk indices, cost arithmetic and result registers
    nwc_datapath #(
        .MAX_SOURCES (MAX_SOURCES),
        .MAX_SINKS   (MAX_SINKS),
        .MASS_WIDTH  (MASS_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .row_index    (row_index),
        .col_index    (col_index),
        .value        (value),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .src_index    (src_index),
        .dst_index    (dst_index),
        .weight       (weight),
        .total_cost   (total_cost),
        .empty_flag   (empty_flag),
        .last         (last)
    );

endmodule

FILE: tb/sv/nwc_tb_pkg.sv
`timescale 1ns / 100ps
// Allocation ledger for the northwest corner transport testbench: mirrors the
// stores and size registers and predicts the allocations of each run.
// Depends on nwc_pkg for the operation codes and register indexes.
package nwc_tb_pkg;

    import nwc_pkg::*;

    typedef struct packed {
        logic [4:0]  src;
        logic [4:0]  dst;
        logic [31:0] weight;
        logic [63:0] total;
        logic        empty;
        logic        last;
    } alloc_t;

    class nwc_alloc_ledger;

        logic [31:0] supply_mass [32];
        logic [31:0] demand_mass [32];
        logic [31:0] cost_word   [32][32];
        bit          cost_set    [32][32];
        logic [5:0]  num_sources;
        logic [5:0]  num_sinks;
        alloc_t      pending_allocs [$];
        alloc_t      walk_q [$];
        int          failures;

        function new();
            foreach (supply_mass[k]) supply_mass[k] = '0;
            foreach (demand_mass[k]) demand_mass[k] = '0;
            foreach (cost_word[r, c]) cost_word[r][c] = '0;
            foreach (cost_set[r, c]) cost_set[r][c] = 1'b0;
            num_sources = 6'd32;
            num_sinks   = 6'd32;
            failures    = 0;
        endfunction

        function int outstanding();
            return pending_allocs.size();
        endfunction

        function void set_size(logic [CFG_IDX_W-1:0] idx, logic [5:0] data);
            if (idx == REG_NUM_SOURCES)
                num_sources = data;
            else
                num_sinks = data;
        endfunction

        // Zero acts as one; anything above the store depth acts as the depth.
        function int eff_size(logic [5:0] v);
            if (v == 0)
                return 1;
            if (v > 32)
                return 32;
            return int'(v);
        endfunction

        function void note_item(op_t o, logic [4:0] row, logic [4:0] col, logic [31:0] val);
            case (o)
                OP_LOAD_SUPPLY: supply_mass[row] = val;
                OP_LOAD_DEMAND: demand_mass[col] = val;
                OP_LOAD_COST:
                begin
                    cost_word[row][col] = val;
                    cost_set[row][col]  = 1'b1;
                end
                default:        walk_corner();
            endcase
        endfunction

        // Walk the corner rule over working copies of the masses into walk_q.
        function void plan_walk();
            logic [31:0] s_left [32];
            logic [31:0] d_left [32];
            alloc_t      a;
            logic [63:0] acc;
            logic [63:0] prod;
            logic [64:0] sum;
            logic [31:0] w;
            int          ns;
            int          nk;
            int          i;
            int          j;
            int          k;
            bit          any_left;
            walk_q.delete();
            ns = eff_size(num_sources);
            nk = eff_size(num_sinks);
            for (k = 0; k < ns; k++) s_left[k] = supply_mass[k];
            for (k = 0; k < nk; k++) d_left[k] = demand_mass[k];
            acc = '0;
            i = 0;
            j = 0;
            while (1) begin
                any_left = 1'b0;
                for (k = 0; k < ns; k++) if (s_left[k] != 0) any_left = 1'b1;
                for (k = 0; k < nk; k++) if (d_left[k] != 0) any_left = 1'b1;
                if (!any_left)
                    break;
                while (i < ns && s_left[i] == 0) i++;
                while (j < nk && d_left[j] == 0) j++;
                if (i >= ns || j >= nk)
                    break;
                w = (s_left[i] < d_left[j]) ? s_left[i] : d_left[j];
                a.src    = 5'(i);
                a.dst    = 5'(j);
                a.weight = w;
                a.total  = '0;
                a.empty  = 1'b0;
                a.last   = 1'b0;
                walk_q   = {walk_q, a};
                prod = 64'(w) * 64'(cost_word[i][j]);
                sum  = 65'(acc) + 65'(prod);
                acc  = sum[64] ? {64{1'b1}} : sum[63:0];
                s_left[i] = s_left[i] - w;
                d_left[j] = d_left[j] - w;
                if (s_left[i] == 0) i++;
                if (d_left[j] == 0) j++;
            end
            if (walk_q.size() == 0) begin
                a = '{src: '0, dst: '0, weight: '0, total: '0, empty: 1'b1, last: 1'b1};
                walk_q = {walk_q, a};
            end else begin
                walk_q[walk_q.size() - 1].total = acc;
                walk_q[walk_q.size() - 1].last  = 1'b1;
            end
        endfunction

        function void walk_corner();
            plan_walk();
            for (int n = 0; n < walk_q.size(); n++)
                pending_allocs = {pending_allocs, walk_q[n]};
        endfunction

        // Find a cost word that the coming walk would read before it is loaded.
        function bit find_unset_cost(output logic [4:0] r, output logic [4:0] c);
            plan_walk();
            r = '0;
            c = '0;
            for (int n = 0; n < walk_q.size(); n++)
            begin
                if (!walk_q[n].empty && !cost_set[walk_q[n].src][walk_q[n].dst])
                begin
                    r = walk_q[n].src;
                    c = walk_q[n].dst;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void check_alloc(alloc_t got);
            alloc_t exp;
            if (pending_allocs.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: src %0d dst %0d weight %0d total %h last %b",
                             got.src, got.dst, got.weight, got.total, got.last);
                return;
            end
            exp = pending_allocs.pop_front();
            if (got.src !== exp.src || got.dst !== exp.dst || got.weight !== exp.weight ||
                got.total !== exp.total || got.empty !== exp.empty || got.last !== exp.last)
            begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch exp: src %0d dst %0d weight %0d total %h empty %b last %b",
                             exp.src, exp.dst, exp.weight, exp.total, exp.empty, exp.last);
                    $display("         got: src %0d dst %0d weight %0d total %h empty %b last %b",
                             got.src, got.dst, got.weight, got.total, got.empty, got.last);
                end
            end
        endfunction

    endclass

endpackage

FILE: tb/sv/tb_northwest_corner_transport_top.sv
`timescale 1ns / 100ps
// Testbench for northwest_corner_transport_top: drives load and run commands,
// predicts every allocation with nwc_tb_pkg and checks each result transfer.
// Depends on nwc_pkg, nwc_tb_pkg and the block's RTL.
module tb_northwest_corner_transport_top;

    import nwc_pkg::*;
    import nwc_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000; // cycles with no transfer before giving up
    localparam int QUIET_CYCLES   = 8;    // covers the closing steps of a run
    localparam int ITEM_TARGET    = 160;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    op_t                   op;
    logic [IDX_W-1:0]      row_index;
    logic [IDX_W-1:0]      col_index;
    logic [VAL_W-1:0]      value;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  result_valid;
    logic [IDX_W-1:0]      src_index;
    logic [IDX_W-1:0]      dst_index;
    logic [WGT_W-1:0]      weight;
    logic [SUM_W-1:0]      total_cost;
    logic                  empty_flag;
    logic                  last;

    nwc_alloc_ledger sb;
    bit              idle_on;
    int              items_sent;
    int              stall_count;

    northwest_corner_transport_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .row_index    (row_index),
        .col_index    (col_index),
        .value        (value),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .src_index    (src_index),
        .dst_index    (dst_index),
        .weight       (weight),
        .total_cost   (total_cost),
        .empty_flag   (empty_flag),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Check every result transfer; the receiver never stalls, so take each strobe.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_alloc('{src: src_index, dst: dst_index, weight: weight,
                             total: total_cost, empty: empty_flag, last: last});
    end

    // Watchdog: count cycles with neither a command nor a result transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_count <= 0;
        else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else
            stall_count <= stall_count + 1;
    end

    // Mass values: many zeros to force skips, mostly small, some near full scale.
    function automatic logic [31:0] pick_mass();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            8:       return $urandom;
            9:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom_range(1, 60);
        endcase
    endfunction

    function automatic logic [31:0] pick_cost();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 20);
        return $urandom;
    endfunction

    // Present one command and hold it until it transfers. Leave start high on
    // return so back-to-back commands keep it asserted without a glitch.
    task automatic send_item(op_t o, logic [4:0] r, logic [4:0] c, logic [31:0] v);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        op        <= o;
        row_index <= r;
        col_index <= c;
        value     <= v;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(o, r, c, v);
        items_sent++;
    endtask

    // Load every cost word the coming walk would read before it is set, then run.
    task automatic send_run(logic [4:0] r, logic [4:0] c, logic [31:0] v);
        logic [4:0] fill_r;
        logic [4:0] fill_c;
        while (sb.find_unset_cost(fill_r, fill_c))
            send_item(OP_LOAD_COST, fill_r, fill_c, pick_cost());
        send_item(OP_RUN, r, c, v);
    endtask

    // Drain all expected results and let a run close before touching the sizes.
    task automatic wait_quiet();
        start <= 1'b0;
        while (sb.outstanding() != 0 || busy) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Write both size registers on consecutive edges, then drop the enable.
    task automatic write_sizes(logic [5:0] src_n, logic [5:0] snk_n);
        cfg_write <= 1'b1;
        cfg_index <= REG_NUM_SOURCES;
        cfg_data  <= src_n;
        @(posedge clk);
        sb.set_size(REG_NUM_SOURCES, src_n);
        cfg_index <= REG_NUM_SINKS;
        cfg_data  <= snk_n;
        @(posedge clk);
        sb.set_size(REG_NUM_SINKS, snk_n);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [5:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 6'($urandom_range(0, 1));
            1:       return 6'($urandom_range(32, 63));
            default: return 6'($urandom_range(1, 8));
        endcase
    endfunction

    // One well-formed sequence: maybe resize, reload a few entries, then run.
    task automatic random_phase();
        int   n_loads;
        int   src_lim;
        int   snk_lim;
        op_t  o;
        logic [4:0] r;
        logic [4:0] c;
        if ($urandom_range(0, 2) == 0) begin
            wait_quiet();
            write_sizes(pick_size(), pick_size());
        end
        src_lim = sb.eff_size(sb.num_sources) - 1;
        snk_lim = sb.eff_size(sb.num_sinks) - 1;
        n_loads = $urandom_range(2, 8);
        repeat (n_loads) begin
            // Mostly hit entries in use; now and then anywhere in the store.
            if ($urandom_range(0, 4) == 0) begin
                r = 5'($urandom_range(0, 31));
                c = 5'($urandom_range(0, 31));
            end else begin
                r = 5'($urandom_range(0, src_lim));
                c = 5'($urandom_range(0, snk_lim));
            end
            case ($urandom_range(0, 2))
                0:       o = OP_LOAD_SUPPLY;
                1:       o = OP_LOAD_DEMAND;
                default: o = OP_LOAD_COST;
            endcase
            send_item(o, r, c, (o == OP_LOAD_COST) ? pick_cost() : pick_mass());
        end
        send_run(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), $urandom);
    endtask

    initial
    begin
        sb = new();
        idle_on    = 1'b1;
        items_sent = 0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        op         <= OP_LOAD_SUPPLY;
        row_index  <= '0;
        col_index  <= '0;
        value      <= '0;
        cfg_write  <= 1'b0;
        cfg_index  <= REG_NUM_SOURCES;
        cfg_data   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every mass entry so no run can read an unwritten one; keep the
        // upper entries empty so full-size walks stay short.
        for (int r = 0; r < 32; r++)
            send_item(OP_LOAD_SUPPLY, 5'(r), 5'd0, (r < 8) ? pick_mass() : 32'd0);
        for (int c = 0; c < 32; c++)
            send_item(OP_LOAD_DEMAND, 5'd0, 5'(c), (c < 8) ? pick_mass() : 32'd0);

        // Full-size walk over both stores.
        wait_quiet();
        write_sizes(6'd32, 6'd32);
        send_run(5'd0, 5'd0, 32'd0);

        // Single cell, equal masses, all values at full scale.
        wait_quiet();
        write_sizes(6'd1, 6'd1);
        send_item(OP_LOAD_SUPPLY, 5'd0, 5'd0, 32'hFFFF_FFFF);
        send_item(OP_LOAD_DEMAND, 5'd0, 5'd0, 32'hFFFF_FFFF);
        send_item(OP_LOAD_COST, 5'd0, 5'd0, 32'hFFFF_FFFF);
        send_run(5'd31, 5'd31, 32'hFFFF_FFFF);

        // Two full-scale diagonal allocations: the cost sum must saturate.
        wait_quiet();
        write_sizes(6'd2, 6'd2);
        send_item(OP_LOAD_SUPPLY, 5'd1, 5'd0, 32'hFFFF_FFFF);
        send_item(OP_LOAD_DEMAND, 5'd0, 5'd1, 32'hFFFF_FFFF);
        send_item(OP_LOAD_COST, 5'd1, 5'd1, 32'hFFFF_FFFF);
        send_run(5'd0, 5'd0, 32'd0);

        // Zero size acts as one; all supply in use is zero, so nothing moves.
        wait_quiet();
        write_sizes(6'd0, 6'd63);
        send_item(OP_LOAD_SUPPLY, 5'd0, 5'd0, 32'd0);
        send_run(5'd0, 5'd0, 32'd0);

        // Oversized sources, single empty sink: again nothing moves.
        wait_quiet();
        write_sizes(6'd63, 6'd0);
        send_item(OP_LOAD_DEMAND, 5'd0, 5'd0, 32'd0);
        send_item(OP_LOAD_SUPPLY, 5'd0, 5'd0, 32'd5);
        send_run(5'd0, 5'd0, 32'd0);

        // Zero entries to skip on both sides, with both larger-side cases.
        wait_quiet();
        write_sizes(6'd4, 6'd3);
        send_item(OP_LOAD_SUPPLY, 5'd0, 5'd0, 32'd0);
        send_item(OP_LOAD_SUPPLY, 5'd1, 5'd0, 32'd7);
        send_item(OP_LOAD_SUPPLY, 5'd2, 5'd0, 32'd0);
        send_item(OP_LOAD_SUPPLY, 5'd3, 5'd0, 32'd3);
        send_item(OP_LOAD_DEMAND, 5'd0, 5'd0, 32'd4);
        send_item(OP_LOAD_DEMAND, 5'd0, 5'd1, 32'd0);
        send_item(OP_LOAD_DEMAND, 5'd0, 5'd2, 32'd6);
        send_run(5'd0, 5'd0, 32'd0);

        // Random sequences; drop idling for the final stretch.
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - 35)
                idle_on = 1'b0;
            random_phase();
        end

        start <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/nwc_pkg.sv
hdl/nwc_controller.sv
hdl/nwc_datapath.sv
hdl/northwest_corner_transport_top.sv
tb/sv/nwc_tb_pkg.sv
tb/sv/tb_northwest_corner_transport_top.sv
